[hdl/dbnc_pkg.sv]
// Shared types and constants for the multi-pin latching debouncer.
package dbnc_pkg;

    // Field widths
    localparam int TIME_W = 32;
    localparam int FIELD_W = 8;
    localparam int PCNT_W = 4;
    localparam int CFG_IDX_W = 2;

    // Default lane count
    localparam int PINS_DEF = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PCNT = 2'd2;

    // Configuration reset values
    localparam logic [TIME_W-1:0] HOLD_RST = 32'd20;
    localparam logic [FIELD_W-1:0] LATCH_RST = 8'd0;
    localparam logic [PCNT_W-1:0] PCNT_RST = 4'd8;

    // Per-lane control for one poll tick
    typedef struct packed {
        logic pressed;
        logic latched;
        logic clear;
        logic active;
    } t_lane_ctl;

    // Per-lane reported status
    typedef struct packed {
        logic stable;
        logic settled;
    } t_lane_sts;

endpackage

[hdl/dbnc_lane.sv]
// One debounce lane: per-pin record and its update for one poll tick.
module dbnc_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  dbnc_pkg::t_lane_ctl         i_ctl,
    input  logic [dbnc_pkg::TIME_W-1:0] i_now,
    input  logic [dbnc_pkg::TIME_W-1:0] i_hold,
    output dbnc_pkg::t_lane_sts         o_next
);

    logic                        r_stable;
    logic                        r_cand;
    logic                        r_settled;
    logic [dbnc_pkg::TIME_W-1:0] r_ctime;

    logic                        n_stable;
    logic                        n_cand;
    logic                        n_settled;
    logic [dbnc_pkg::TIME_W-1:0] n_ctime;

    // Clear first, then the timestamp update unless frozen or inactive
    always_comb begin
        n_stable  = r_stable;
        n_cand    = r_cand;
        n_settled = r_settled;
        n_ctime   = r_ctime;
        if (i_ctl.clear) begin
            n_stable  = 1'b0;
            n_cand    = 1'b0;
            n_settled = 1'b0;
            n_ctime   = '0;
        end
        if (i_ctl.active && !(i_ctl.latched && n_settled && n_stable)) begin
            // leaving a settled level restarts the timer
            if (n_settled && (i_ctl.pressed != n_stable)) begin
                n_settled = 1'b0;
                n_ctime   = '0;
            end
            // new candidate, or fresh start
            if ((i_ctl.pressed != n_cand) || (n_ctime == '0)) begin
                n_ctime = i_now;
                n_cand  = i_ctl.pressed;
            end
            // held long enough (modular difference)
            if ((i_now - n_ctime) > i_hold) begin
                n_stable  = n_cand;
                n_settled = 1'b1;
                n_ctime   = '0;
            end
        end
    end

    // Record update on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable  <= 1'b0;
            r_cand    <= 1'b0;
            r_settled <= 1'b0;
            r_ctime   <= '0;
        end else if (i_en) begin
            r_stable  <= n_stable;
            r_cand    <= n_cand;
            r_settled <= n_settled;
            r_ctime   <= n_ctime;
        end
    end

    assign o_next.stable  = n_stable;
    assign o_next.settled = n_settled;

endmodule

[hdl/dbnc_merge.sv]
// Merges lane status into the result masks; output register plus skid stage.
module dbnc_merge #(
    parameter int PINS = dbnc_pkg::PINS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  dbnc_pkg::t_lane_sts          i_sts [PINS],
    input  logic                         i_out_stall,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output logic [dbnc_pkg::FIELD_W-1:0] o_stable_pressed,
    output logic [dbnc_pkg::FIELD_W-1:0] o_settled_mask
);

    logic [dbnc_pkg::FIELD_W-1:0] w_stable;
    logic [dbnc_pkg::FIELD_W-1:0] w_settled;

    logic                         r_out_vld;
    logic [dbnc_pkg::FIELD_W-1:0] r_out_stable;
    logic [dbnc_pkg::FIELD_W-1:0] r_out_settled;
    logic                         r_skid_vld;
    logic [dbnc_pkg::FIELD_W-1:0] r_skid_stable;
    logic [dbnc_pkg::FIELD_W-1:0] r_skid_settled;

    logic                         n_out_vld;
    logic [dbnc_pkg::FIELD_W-1:0] n_out_stable;
    logic [dbnc_pkg::FIELD_W-1:0] n_out_settled;
    logic                         n_skid_vld;
    logic [dbnc_pkg::FIELD_W-1:0] n_skid_stable;
    logic [dbnc_pkg::FIELD_W-1:0] n_skid_settled;

    // Gather lane bits; lanes beyond the field width are not reported
    for (genvar j = 0; j < dbnc_pkg::FIELD_W; j++) begin : g_gather
        if (j < PINS) begin : g_lane
            assign w_stable[j]  = i_sts[j].stable;
            assign w_settled[j] = i_sts[j].settled;
        end else begin : g_none
            assign w_stable[j]  = 1'b0;
            assign w_settled[j] = 1'b0;
        end
    end

    // Output register and skid stage
    always_comb begin
        n_out_vld      = r_out_vld;
        n_out_stable   = r_out_stable;
        n_out_settled  = r_out_settled;
        n_skid_vld     = r_skid_vld;
        n_skid_stable  = r_skid_stable;
        n_skid_settled = r_skid_settled;
        if (!r_out_vld || !i_out_stall) begin
            if (r_skid_vld) begin
                n_out_vld     = 1'b1;
                n_out_stable  = r_skid_stable;
                n_out_settled = r_skid_settled;
                n_skid_vld    = 1'b0;
            end else begin
                n_out_vld     = i_load;
                n_out_stable  = w_stable;
                n_out_settled = w_settled;
            end
        end else if (i_load) begin
            n_skid_vld     = 1'b1;
            n_skid_stable  = w_stable;
            n_skid_settled = w_settled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out_stable   <= n_out_stable;
        r_out_settled  <= n_out_settled;
        r_skid_stable  <= n_skid_stable;
        r_skid_settled <= n_skid_settled;
    end

    assign o_in_stall       = r_skid_vld;
    assign o_out_valid      = r_out_vld;
    assign o_stable_pressed = r_out_stable;
    assign o_settled_mask   = r_out_settled;

endmodule

[hdl/multi_pin_latching_debouncer_unit.sv]
// Top level of the multi-pin latching debouncer: config registers, lanes, merge.
// Each result is registered in the output register, or in the skid entry under a stall.
// Throughput: one poll tick per cycle unless input stalls; all pins update side by side.
// Output register plus skid entry: under a held output stall one more transfer is taken,
// then input stalls until the waiting result leaves.
// Reset clears every pin record and loads the register defaults; no clearing pass.
module multi_pin_latching_debouncer_unit #(
    parameter int PINS = dbnc_pkg::PINS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // poll tick channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dbnc_pkg::TIME_W-1:0]    i_now_ticks,
    input  logic [dbnc_pkg::FIELD_W-1:0]   i_raw_levels,
    input  logic [dbnc_pkg::FIELD_W-1:0]   i_clear_mask,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dbnc_pkg::FIELD_W-1:0]   o_stable_pressed,
    output logic [dbnc_pkg::FIELD_W-1:0]   o_settled_mask,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dbnc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dbnc_pkg::TIME_W-1:0]    i_cfg_data
);

    logic [dbnc_pkg::TIME_W-1:0]  r_hold;
    logic [dbnc_pkg::FIELD_W-1:0] r_latch;
    logic [dbnc_pkg::PCNT_W-1:0]  r_pcnt;

    logic                         w_in_xfer;
    dbnc_pkg::t_lane_ctl          w_ctl [PINS];
    dbnc_pkg::t_lane_sts          w_sts [PINS];

    // Configuration registers, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= dbnc_pkg::HOLD_RST;
            r_latch <= dbnc_pkg::LATCH_RST;
            r_pcnt  <= dbnc_pkg::PCNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dbnc_pkg::CFG_IDX_HOLD:  r_hold  <= i_cfg_data;
                dbnc_pkg::CFG_IDX_LATCH: r_latch <= i_cfg_data[dbnc_pkg::FIELD_W-1:0];
                dbnc_pkg::CFG_IDX_PCNT:  r_pcnt  <= i_cfg_data[dbnc_pkg::PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && !o_in_stall;

    // Lane control and lanes; pins past the field width read pressed, never latch or clear
    for (genvar i = 0; i < PINS; i++) begin : g_lane
        if (i < dbnc_pkg::FIELD_W) begin : g_field
            assign w_ctl[i].pressed = ~i_raw_levels[i];
            assign w_ctl[i].latched = r_latch[i];
            assign w_ctl[i].clear   = i_clear_mask[i];
        end else begin : g_wide
            assign w_ctl[i].pressed = 1'b1;
            assign w_ctl[i].latched = 1'b0;
            assign w_ctl[i].clear   = 1'b0;
        end
        assign w_ctl[i].active =
            (32'(i) < {{(32 - dbnc_pkg::PCNT_W){1'b0}}, r_pcnt});

        dbnc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_in_xfer),
            .i_ctl   (w_ctl[i]),
            .i_now   (i_now_ticks),
            .i_hold  (r_hold),
            .o_next  (w_sts[i])
        );
    end

    // Merge into result masks
    dbnc_merge #(
        .PINS (PINS)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_in_xfer),
        .i_sts            (w_sts),
        .i_out_stall      (i_out_stall),
        .o_in_stall       (o_in_stall),
        .o_out_valid      (o_out_valid),
        .o_stable_pressed (o_stable_pressed),
        .o_settled_mask   (o_settled_mask)
    );

`ifndef SYNTHESIS
    // Skid entry only holds data behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid full while output register empty");

    // After every transfer the output register holds a valid result in the next cycle
    a_xfer_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_out_valid)
        else $error("transfer without a result");

    // A transfer behind a stalled result fills the skid stage
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && o_out_valid && i_out_stall) |=> o_in_stall)
        else $error("result dropped under output stall");
`endif

endmodule

[test/dbnc_checker.sv]
`timescale 1ns / 100ps
// Checker for the debouncer: watches all channels, predicts each poll result and compares.
module dbnc_checker #(
    parameter int PINS = dbnc_pkg::PINS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // poll tick channel
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [dbnc_pkg::TIME_W-1:0]    i_now_ticks,
    input  logic [dbnc_pkg::FIELD_W-1:0]   i_raw_levels,
    input  logic [dbnc_pkg::FIELD_W-1:0]   i_clear_mask,
    // result channel
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [dbnc_pkg::FIELD_W-1:0]   i_stable_pressed,
    input  logic [dbnc_pkg::FIELD_W-1:0]   i_settled_mask,
    // configuration write channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [dbnc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dbnc_pkg::TIME_W-1:0]    i_cfg_data,
    // status toward the testbench top
    output int                             o_fail_count,
    output int                             o_pending
);
    import dbnc_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] stable;
        logic [FIELD_W-1:0] settled;
    } t_pin_status;

    // Shadow copy of the configuration registers
    logic [TIME_W-1:0]  hold_cfg = HOLD_RST;
    logic [FIELD_W-1:0] latch_cfg = LATCH_RST;
    logic [PCNT_W-1:0]  pcnt_cfg = PCNT_RST;

    // Shadow copy of the per-pin debounce records
    logic [PINS-1:0]   stable_lvl = '0;
    logic [PINS-1:0]   cand_lvl = '0;
    logic [PINS-1:0]   settled_flg = '0;
    logic [TIME_W-1:0] chg_time [PINS];

    t_pin_status expected_status_q [$];
    int          mismatch_count = 0;

    // One poll tick: clears first, then the counted pins update, then report.
    function automatic t_pin_status debounce_poll(input logic [TIME_W-1:0]  now,
                                                  input logic [FIELD_W-1:0] raw,
                                                  input logic [FIELD_W-1:0] clr);
        int                cnt;
        logic              pressed;
        logic              latched;
        logic [TIME_W-1:0] elapsed;
        t_pin_status       res;
        cnt = (pcnt_cfg > PINS) ? PINS : int'(pcnt_cfg);
        for (int i = 0; i < PINS; i++) begin
            if (i < FIELD_W && clr[i]) begin
                stable_lvl[i] = 1'b0;
                cand_lvl[i] = 1'b0;
                settled_flg[i] = 1'b0;
                chg_time[i] = '0;
            end
        end
        for (int i = 0; i < cnt; i++) begin
            // pins past the field width read as pressed and never latch
            pressed = (i < FIELD_W) ? ~raw[i] : 1'b1;
            latched = (i < FIELD_W) ? latch_cfg[i] : 1'b0;
            // a latched pin held stably pressed is frozen
            if (!(latched && settled_flg[i] && stable_lvl[i])) begin
                if (settled_flg[i] && pressed != stable_lvl[i]) begin
                    settled_flg[i] = 1'b0;
                    chg_time[i] = '0;
                end
                // new candidate, or a zero time stamp means start over
                if (pressed != cand_lvl[i] || chg_time[i] == '0) begin
                    chg_time[i] = now;
                    cand_lvl[i] = pressed;
                end
                elapsed = now - chg_time[i];
                if (elapsed > hold_cfg) begin
                    stable_lvl[i] = cand_lvl[i];
                    settled_flg[i] = 1'b1;
                    chg_time[i] = '0;
                end
            end
        end
        res = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (i < PINS) begin
                res.stable[i] = stable_lvl[i];
                res.settled[i] = settled_flg[i];
            end
        end
        return res;
    endfunction

    initial begin
        for (int i = 0; i < PINS; i++) chg_time[i] = '0;
    end

    // Sample every channel at the clock edge
    always @(posedge i_clk) begin
        t_pin_status want;
        if (!i_rst_n) begin
            hold_cfg = HOLD_RST;
            latch_cfg = LATCH_RST;
            pcnt_cfg = PCNT_RST;
            stable_lvl = '0;
            cand_lvl = '0;
            settled_flg = '0;
            for (int i = 0; i < PINS; i++) chg_time[i] = '0;
            expected_status_q.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_HOLD:  hold_cfg = i_cfg_data;
                    CFG_IDX_LATCH: latch_cfg = i_cfg_data[FIELD_W-1:0];
                    CFG_IDX_PCNT:  pcnt_cfg = i_cfg_data[PCNT_W-1:0];
                    default: ;
                endcase
            end
            // poll tick transfer: predict its result
            if (i_in_valid && !i_in_stall) begin
                expected_status_q.push_back(debounce_poll(i_now_ticks, i_raw_levels,
                                                          i_clear_mask));
            end
            // result transfer: compare with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_status_q.size() == 0) begin
                    $error("unexpected result: stable_pressed %02h settled_mask %02h",
                           i_stable_pressed, i_settled_mask);
                    mismatch_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (i_stable_pressed !== want.stable) begin
                        $error("stable_pressed: expected %02h, actual %02h",
                               want.stable, i_stable_pressed);
                        mismatch_count++;
                    end
                    if (i_settled_mask !== want.settled) begin
                        $error("settled_mask: expected %02h, actual %02h",
                               want.settled, i_settled_mask);
                        mismatch_count++;
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending <= expected_status_q.size();
    end

endmodule

[test/tb_multi_pin_latching_debouncer_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the debouncer: clock, reset, poll tick stimulus, output stalls, verdict.
module tb_multi_pin_latching_debouncer_unit;
    import dbnc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [TIME_W-1:0]    i_now_ticks;
    logic [FIELD_W-1:0]   i_raw_levels;
    logic [FIELD_W-1:0]   i_clear_mask;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [FIELD_W-1:0]   o_stable_pressed;
    logic [FIELD_W-1:0]   o_settled_mask;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TIME_W-1:0]    i_cfg_data;

    int fail_count;
    int pending;

    // Sender pacing and shared stimulus state
    bit                 hold_off_req = 1'b0;
    bit                 steady_send = 1'b0;
    int                 burst_left = 0;
    logic [TIME_W-1:0]  tick_now = '0;
    logic [FIELD_W-1:0] pin_target = '1;
    int                 bounce_left [FIELD_W];

    multi_pin_latching_debouncer_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_now_ticks      (i_now_ticks),
        .i_raw_levels     (i_raw_levels),
        .i_clear_mask     (i_clear_mask),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_stable_pressed (o_stable_pressed),
        .o_settled_mask   (o_settled_mask),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    dbnc_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_now_ticks      (i_now_ticks),
        .i_raw_levels     (i_raw_levels),
        .i_clear_mask     (i_clear_mask),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_stable_pressed (o_stable_pressed),
        .i_settled_mask   (o_settled_mask),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop for a hung run
    initial begin
        #1000000;
        $display("[multi_pin_latching_debouncer_unit] ERROR");
        $finish;
    end

    // Receiver: stall pattern that changes mode now and then, plus requested hold-offs
    initial begin : out_stall_gen
        t_stall_mode mode;
        int          mode_left;
        int          cyc;
        mode = STALL_NONE;
        mode_left = 100;
        cyc = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                cyc++;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ((cyc % 5) < 2);
                endcase
            end
        end
    end

    // Offer one poll tick and wait for its transfer; idle between bursts
    task automatic send_tick(input logic [TIME_W-1:0]  now,
                             input logic [FIELD_W-1:0] raw,
                             input logic [FIELD_W-1:0] clr);
        int gap;
        i_in_valid <= 1'b1;
        i_now_ticks <= now;
        i_raw_levels <= raw;
        i_clear_mask <= clr;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 && !steady_send) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending until every predicted result has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back; junk in unused upper data bits
    task automatic write_config(input logic [TIME_W-1:0]  hold,
                                input logic [FIELD_W-1:0] latch,
                                input logic [PCNT_W-1:0]  pcnt);
        logic [TIME_W-1:0]    junk;
        logic [TIME_W-1:0]    data;
        logic [CFG_IDX_W-1:0] idx;
        for (int r = 0; r < 3; r++) begin
            junk = ($urandom_range(0, 1) == 0) ? '0 : TIME_W'($urandom);
            case (r)
                0: begin
                    idx = CFG_IDX_HOLD;
                    data = hold;
                end
                1: begin
                    idx = CFG_IDX_LATCH;
                    data = {junk[TIME_W-1:FIELD_W], latch};
                end
                default: begin
                    idx = CFG_IDX_PCNT;
                    data = {junk[TIME_W-1:PCNT_W], pcnt};
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random poll ticks: bouncy presses and releases over a running clock,
    // with some noise, clears, time-zero ticks and time jumps.
    task automatic run_phase(input int n_items, input bit big_steps, input bit with_hold_off);
        logic [FIELD_W-1:0] raw;
        logic [FIELD_W-1:0] clr;
        int                 step_kind;
        tick_now = $urandom;
        for (int n = 0; n < n_items; n++) begin
            if (n % 60 == 0) steady_send = ($urandom_range(0, 3) == 0);
            // long receiver hold-off while the sender keeps offering
            if (with_hold_off && n == n_items / 3) begin
                steady_send = 1'b1;
                hold_off_req = 1'b1;
            end
            if (n == n_items / 2) wait_drained();

            step_kind = $urandom_range(0, 63);
            if (step_kind == 0)
                tick_now = '0;
            else if (step_kind == 1 || (big_steps && step_kind < 32))
                tick_now = tick_now + TIME_W'($urandom);
            else
                tick_now = tick_now + TIME_W'($urandom_range(0, 3));

            for (int p = 0; p < FIELD_W; p++) begin
                if ($urandom_range(0, 19) == 0) begin
                    pin_target[p] = ~pin_target[p];
                    bounce_left[p] = $urandom_range(0, 4);
                end
                if (bounce_left[p] > 0) begin
                    raw[p] = 1'($urandom_range(0, 1));
                    bounce_left[p]--;
                end else begin
                    raw[p] = pin_target[p];
                end
            end
            if ($urandom_range(0, 9) == 0) raw = FIELD_W'($urandom);
            clr = ($urandom_range(0, 19) == 0) ? FIELD_W'($urandom) : '0;
            send_tick(tick_now, raw, clr);
        end
    endtask

    initial begin : stimulus
        for (int p = 0; p < FIELD_W; p++) bounce_left[p] = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_now_ticks <= '0;
        i_raw_levels <= '0;
        i_clear_mask <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IDX_HOLD;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default registers, time zero, wrap-around, clear with update,
        // strict hold compare, change away from a settled level
        send_tick(32'h0000_0000, 8'hFF, 8'h00);
        send_tick(32'hFFFF_FFFF, 8'h00, 8'h00);
        send_tick(32'h0000_0014, 8'h00, 8'h00);
        send_tick(32'h0000_0015, 8'h00, 8'hFF);
        send_tick(32'h0000_002A, 8'h00, 8'h00);
        send_tick(32'h0000_002B, 8'h55, 8'h00);
        send_tick(32'h0000_003F, 8'h55, 8'h00);
        send_tick(32'h0000_0040, 8'h55, 8'h00);
        send_tick(32'h0000_0000, 8'hAA, 8'h00);
        send_tick(32'h0000_0100, 8'hAA, 8'h00);
        send_tick(32'h0000_0200, 8'hAA, 8'h00);
        // upper pins not counted but latched
        wait_drained();
        write_config(32'd20, 8'hF0, 4'd4);
        send_tick(32'h0000_0300, 8'h00, 8'h00);
        send_tick(32'h0000_0400, 8'h00, 8'h00);
        // latched pins freeze pressed, then a clear releases them
        wait_drained();
        write_config(32'd20, 8'hF0, 4'd8);
        send_tick(32'h0000_0500, 8'h00, 8'h00);
        send_tick(32'h0000_0600, 8'hFF, 8'h00);
        send_tick(32'h0000_0601, 8'hFF, 8'h50);
        // pin count above the number of pins, zero hold
        wait_drained();
        write_config(32'd0, 8'h00, 4'd15);
        send_tick(32'h0000_0700, 8'h0F, 8'h00);
        send_tick(32'h0000_0701, 8'h0F, 8'h00);
        send_tick(32'hFFFF_FFFF, 8'hF0, 8'hAA);
        // no pins counted, largest hold: only clears act
        wait_drained();
        write_config(32'hFFFF_FFFF, 8'hFF, 4'd0);
        send_tick(32'h0000_0000, 8'h00, 8'h0F);
        send_tick(32'h0000_0800, 8'h00, 8'h00);
        send_tick(32'hFFFF_FFFF, 8'hFF, 8'hFF);

        // Random phases over a range of register settings
        wait_drained();
        write_config(32'd3, 8'h00, 4'd8);
        run_phase(240, 1'b0, 1'b1);
        wait_drained();
        write_config(32'd0, 8'hFF, 4'd8);
        run_phase(240, 1'b0, 1'b0);
        wait_drained();
        write_config(TIME_W'($urandom_range(1, 12)), FIELD_W'($urandom),
                     PCNT_W'($urandom_range(0, 15)));
        run_phase(240, 1'b0, 1'b1);
        wait_drained();
        write_config(32'hFFFF_FFFF, FIELD_W'($urandom), 4'd15);
        run_phase(200, 1'b1, 1'b0);
        wait_drained();
        write_config(32'h8000_0000 | TIME_W'($urandom), FIELD_W'($urandom), 4'd8);
        run_phase(240, 1'b1, 1'b0);
        wait_drained();
        write_config(32'd0, FIELD_W'($urandom), 4'd0);
        run_phase(240, 1'b0, 1'b0);
        wait_drained();
        write_config(TIME_W'($urandom_range(2, 30)), FIELD_W'($urandom), 4'd8);
        run_phase(240, 1'b0, 1'b1);
        wait_drained();
        write_config(32'd5, 8'hFF, PCNT_W'($urandom_range(1, 7)));
        run_phase(300, 1'b0, 1'b0);

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("[multi_pin_latching_debouncer_unit] OK");
        else
            $display("[multi_pin_latching_debouncer_unit] ERROR");
        $finish;
    end

endmodule
